// ----- hw/rtl/mrpt_pkg.sv -----
// shared types and constants for the miller-rabin primality tester
// no dependencies
`default_nettype none
package mrpt_pkg;
   localparam int BASE_COUNT = 12;
   localparam int BASE_W     = 6;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SHIFT = 9'b000000010,
      ST_BASE  = 9'b000000100,
      ST_POW   = 9'b000001000,
      ST_MULR  = 9'b000010000,
      ST_MULB  = 9'b000100000,
      ST_SQ    = 9'b001000000,
      ST_SQW   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   function automatic logic [BASE_W-1:0] witness_base(input logic [3:0] idx);
      logic [BASE_W-1:0] v;
      case (idx)
         4'd0:    v = 6'd2;
         4'd1:    v = 6'd3;
         4'd2:    v = 6'd5;
         4'd3:    v = 6'd7;
         4'd4:    v = 6'd11;
         4'd5:    v = 6'd13;
         4'd6:    v = 6'd17;
         4'd7:    v = 6'd19;
         4'd8:    v = 6'd23;
         4'd9:    v = 6'd29;
         4'd10:   v = 6'd31;
         4'd11:   v = 6'd37;
         default: v = 6'd37;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mrpt_modmul.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle (double and add)
// uses mrpt_pkg
`default_nettype none
module mrpt_modmul import mrpt_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] op_x,
   input  wire logic [WIDTH-1:0] op_y,
   input  wire logic [WIDTH-1:0] modulus,
   output logic                  done,
   output logic [WIDTH-1:0]      product
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in, x_ff, y_ff, m_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [WIDTH:0]   dbl, sum;
   logic [WIDTH-1:0] t;

   always_comb begin
      dbl = {acc_ff, 1'b0};
      t   = (dbl >= {1'b0, m_ff}) ? WIDTH'(dbl - {1'b0, m_ff}) : dbl[WIDTH-1:0];
      sum = {1'b0, t} + {1'b0, x_ff};
      if (y_ff[WIDTH-1]) begin
         acc_in = (sum >= {1'b0, m_ff}) ? WIDTH'(sum - {1'b0, m_ff}) : sum[WIDTH-1:0];
      end else begin
         acc_in = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         acc_ff <= '0;
         x_ff   <= op_x;
         y_ff   <= op_y;
         m_ff   <= modulus;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= {y_ff[WIDTH-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("multiplier restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/miller_rabin_primality_test.sv -----
// miller-rabin primality tester top level: sequencer over one shared modmul
// a candidate takes up to about NUM_WITNESSES * (2*WIDTH + s) modular multiplications,
// fewer for trivial candidates; one request at a time
// a finished result waits in the output register while the next request is taken
// reset: synchronous active high, clears sequencer and output valid
`default_nettype none
module miller_rabin_primality_test import mrpt_pkg::*; #(
   parameter int WIDTH         = 64,
   parameter int NUM_WITNESSES = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // candidate
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // is_prime, zero fill
);
   localparam int CW = $clog2(WIDTH + 1);

   state_type        state_ff;
   logic [WIDTH-1:0] n_ff, d_ff, r_ff, b_ff, e_ff, x_ff;
   logic [CW-1:0]    s_ff, k_ff;
   logic [3:0]       i_ff;
   logic             res_ff, out_ff, rsp_valid_ff;
   logic             mul_start, mul_done;
   logic [WIDTH-1:0] mul_x, mul_y, mul_p, nm1, base_ext, n_in;

   assign n_in     = req_tdata[WIDTH-1:0];
   assign nm1      = n_ff - 1'b1;
   assign base_ext = {{(WIDTH-BASE_W){1'b0}}, witness_base(i_ff)};

   always_comb begin
      mul_start = 1'b0;
      mul_x     = r_ff;
      mul_y     = b_ff;
      case (state_ff)
         ST_POW:  mul_start = (e_ff != '0) && e_ff[0];
         ST_MULR: begin
            mul_start = mul_done;
            mul_x     = b_ff;
         end
         ST_SQ: begin
            mul_start = (k_ff < s_ff);
            mul_x     = x_ff;
            mul_y     = x_ff;
         end
         default: mul_start = 1'b0;
      endcase
      if (state_ff == ST_POW && e_ff != '0 && !e_ff[0]) begin
         mul_start = 1'b1;
         mul_x     = b_ff;
      end
   end

   mrpt_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_x(mul_x), .op_y(mul_y),
      .modulus(n_ff), .done(mul_done), .product(mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)                    rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  n_ff <= n_in;
                  d_ff <= n_in - 1'b1;
                  s_ff <= '0;
                  i_ff <= '0;
                  if (n_in < WIDTH'(2)) begin
                     res_ff   <= 1'b0;
                     state_ff <= ST_FIN;
                  end else if (n_in == WIDTH'(2) || n_in == WIDTH'(3)) begin
                     res_ff   <= 1'b1;
                     state_ff <= ST_FIN;
                  end else if (!n_in[0]) begin
                     res_ff   <= 1'b0;
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (d_ff[0]) begin
                  state_ff <= ST_BASE;
               end else begin
                  d_ff <= d_ff >> 1;
                  s_ff <= s_ff + 1'b1;
               end
            end
            ST_BASE: begin
               if (i_ff == 4'(NUM_WITNESSES) || n_ff <= base_ext) begin
                  res_ff   <= 1'b1;
                  state_ff <= ST_FIN;
               end else begin
                  r_ff     <= WIDTH'(1);
                  b_ff     <= base_ext;
                  e_ff     <= d_ff;
                  state_ff <= ST_POW;
               end
            end
            ST_POW: begin
               if (e_ff == '0) begin
                  x_ff <= r_ff;
                  k_ff <= CW'(1);
                  i_ff <= i_ff + 1'b1;
                  if (r_ff == WIDTH'(1) || r_ff == nm1) state_ff <= ST_BASE;
                  else                                  state_ff <= ST_SQ;
               end else if (e_ff[0]) begin
                  state_ff <= ST_MULR;
               end else begin
                  state_ff <= ST_MULB;
               end
            end
            ST_MULR: begin
               if (mul_done) begin
                  r_ff     <= mul_p;
                  state_ff <= ST_MULB;
               end
            end
            ST_MULB: begin
               if (mul_done) begin
                  b_ff     <= mul_p;
                  e_ff     <= e_ff >> 1;
                  state_ff <= ST_POW;
               end
            end
            ST_SQ: begin
               if (k_ff < s_ff) begin
                  state_ff <= ST_SQW;
               end else begin
                  res_ff   <= 1'b0;
                  state_ff <= ST_FIN;
               end
            end
            ST_SQW: begin
               if (mul_done) begin
                  x_ff <= mul_p;
                  k_ff <= k_ff + 1'b1;
                  if (mul_p == nm1) state_ff <= ST_BASE;
                  else              state_ff <= ST_SQ;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  out_ff       <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff};

`ifndef SYNTHESIS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready right after request");
   a_start_idle_mul: assert property (@(posedge clock) disable iff (reset)
      mul_start |=> !mul_start) else $error("back to back multiplier start");
   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result not posted");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/primality_checker.sv -----
// checker for the primality tester: watches request and response channels,
// predicts each verdict with its own miller-rabin routine and compares in order
// depends on nothing but the channel signals
`timescale 1ns / 1ps
module primality_checker #(
   parameter int WIDTH         = 64,
   parameter int NUM_WITNESSES = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // candidate
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // is_prime, zero fill
   output int               error_count,
   output int               pending_verdicts,
   output int               prime_count,
   output int               verdict_count
);
   logic [7:0] expected_verdicts[$];
   logic [7:0] want;

   function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
      logic [63:0] r;
      r = 64'd1;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = mulmod(r, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic is_prime_pred(input logic [63:0] raw);
      logic [63:0] n, d, nm1, x, a;
      logic [63:0] primes[12];
      int s;
      logic ok;
      primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      n = (WIDTH >= 64) ? raw : (raw & ((64'd1 << WIDTH) - 1));
      if (n < 2) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (!n[0]) return 1'b0;
      nm1 = n - 1;
      d = nm1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < NUM_WITNESSES && i < 12; i++) begin
         a = primes[i];
         if (n <= a) break;
         x = powmod(a, d, n);
         if (x == 1 || x == nm1) continue;
         ok = 1'b0;
         for (int r = 1; r < s; r++) begin
            x = mulmod(x, x, n);
            if (x == nm1) begin
               ok = 1'b1;
               break;
            end
         end
         if (!ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   assign pending_verdicts = expected_verdicts.size();

   always @(posedge clock) begin
      if (reset) begin
         error_count   <= 0;
         prime_count   <= 0;
         verdict_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_verdicts.push_back({7'd0, is_prime_pred(req_tdata)});
         if (rsp_tvalid && rsp_tready) begin
            verdict_count <= verdict_count + 1;
            if (rsp_tdata[0]) prime_count <= prime_count + 1;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: verdict mismatch, expected %h, actual %h", $time, want,
                           rsp_tdata);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/sv/testbench.sv -----
// top of the primality tester bench: clock, reset, request stimulus with random
// gaps and response backpressure; depends on primality_checker and the block
`timescale 1ns / 1ps
module testbench;
   localparam int ITEM_COUNT = 116;
   localparam int CYCLE_LIMIT = 100000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // candidate
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // is_prime, zero fill
   int          error_count, pending_verdicts, prime_count, verdict_count;
   int          cycle_count;
   bit          long_hold;
   logic [63:0] directed[$];

   miller_rabin_primality_test i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   primality_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_verdicts(pending_verdicts),
      .prime_count(prime_count), .verdict_count(verdict_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_candidate();
      int k;
      logic [63:0] v;
      k = $urandom_range(0, 9);
      case (k)
         0, 1, 2: v = 64'($urandom_range(0, 1000));
         3, 4:    v = {32'd0, $urandom} | 64'd1;
         5:       v = rand64() & ~64'd1;
         default: v = rand64() | 64'd1;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) cycle_count <= 0;
      else cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side backpressure
   initial begin
      int hold;
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold && !held) begin
            rsp_tready <= 1'b0;
            repeat (20000) @(posedge clock);
            held = 1'b1;
         end
         hold = gap_len();
         if (hold == 0 || $urandom_range(0, 1)) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic [63:0] value);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      int wait_cycles;
      long_hold  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd37, 64'd41,
                   64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751,
                   64'd3825123056546413051, 64'd341550071728321,
                   64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFC5, 64'hFFFFFFFFFFFFFFFE,
                   64'h8000000000000000, 64'h7FFFFFFFFFFFFFFF, 64'd4294967291,
                   64'd1000000007, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAB};
      foreach (directed[i]) send_request(directed[i]);
      // sender waits until every verdict is back
      req_tvalid <= 1'b0;
      while (pending_verdicts != 0) @(posedge clock);
      long_hold = 1'b1;
      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i == 60) begin
            req_tvalid <= 1'b0;
            while (pending_verdicts != 0) @(posedge clock);
         end
         send_request(random_candidate());
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_verdicts != 0 && wait_cycles < 3000000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      $display("tested %0d candidates: edge values, strong pseudoprimes and random ones",
               verdict_count);
      $display("%0d reported prime, %0d composite", prime_count,
               verdict_count - prime_count);
      if (error_count == 0 && pending_verdicts == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_modmul.sv
hw/rtl/miller_rabin_primality_test.sv
tb/sv/primality_checker.sv
tb/sv/testbench.sv
